@@ sv/fcc16_pkg.sv @@
// Package: shared types, status codes, sizes and the CRC byte step for the frame checker.
package fcc16_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [8:0] MIN_FRAME_M1  = 9'd8;     // minimum frame length of nine bytes, minus one
    localparam logic [8:0] PAYLOAD_START = 9'd9;
    localparam logic [8:0] COUNT_MAX     = 9'd511;

    localparam logic [1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [1:0] CFG_CRC_POLY    = 2'd2;
    localparam logic [1:0] CFG_PAY_LIMIT   = 2'd3;
    localparam int         CFG_INDEX_W     = 8;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_TOO_SHORT = 3'd1;
    localparam logic [2:0] ST_BAD_SYNC  = 3'd2;
    localparam logic [2:0] ST_TOO_LONG  = 3'd3;
    localparam logic [2:0] ST_CRC_BAD   = 3'd4;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_frame;
    } t_in;

    typedef struct packed {
        logic        result_kind;
        logic [7:0]  payload_byte;
        logic [7:0]  src_addr;
        logic [7:0]  dest_node;
        logic [7:0]  message_type;
        logic [15:0] message_id;
        logic [15:0] received_crc;
        logic [7:0]  payload_length;
        logic [2:0]  status;
        logic        last_of_run;
    } t_out;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [15:0] crc_polynomial;
        logic [7:0]  payload_limit;
    } t_cfg;

    // One classified input byte: an optional payload byte and an optional summary.
    typedef struct packed {
        logic        pay_valid;
        logic [7:0]  pay_byte;
        logic        sum_valid;
        logic [7:0]  src_addr;
        logic [7:0]  dest_node;
        logic [7:0]  message_type;
        logic [15:0] message_id;
        logic [15:0] received_crc;
        logic [15:0] crc_calc;
        logic [7:0]  payload_length;
        logic        too_short;
        logic        sync_ok;
        logic        too_long;
    } t_work;

    // MSB-first CRC-16 update over one byte.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data,
                                             input logic [15:0] poly);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (crc[15]) crc = {crc[14:0], 1'b0} ^ poly;
            else         crc = {crc[14:0], 1'b0};
        end
        return crc;
    endfunction

endpackage

@@ sv/fcc16_front.sv @@
// Front end: accepts frame bytes, tracks position, header, delay line and CRC, classifies.
module fcc16_front (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  fcc16_pkg::t_in        i_in,
    input  fcc16_pkg::t_cfg       i_cfg,
    output logic                  o_push,
    output fcc16_pkg::t_work      o_work
);
    import fcc16_pkg::*;

    logic [8:0]  r_count, n_count;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_newer, n_newer;
    logic [7:0]  r_older, n_older;
    logic        r_sync, n_sync;
    logic [7:0]  r_src, n_src;
    logic [7:0]  r_dst, n_dst;
    logic [7:0]  r_typ, n_typ;
    logic [15:0] r_id, n_id;

    logic [8:0]  diff;
    logic        last;
    logic [7:0]  b;

    assign b    = i_in.data_byte;
    assign last = i_in.end_of_frame;
    assign diff = r_count - MIN_FRAME_M1;

    always_comb begin
        n_src  = (r_count == 9'd2) ? b : r_src;
        n_dst  = (r_count == 9'd3) ? b : r_dst;
        n_typ  = (r_count == 9'd4) ? b : r_typ;
        n_id   = r_id;
        if (r_count == 9'd5) n_id[7:0]  = b;
        if (r_count == 9'd6) n_id[15:8] = b;
        n_sync = r_sync;
        if (r_count == 9'd0 && b != i_cfg.sync_first)  n_sync = 1'b0;
        if (r_count == 9'd1 && b != i_cfg.sync_second) n_sync = 1'b0;
        n_crc  = (r_count >= 9'd2) ? crc_byte(r_crc, r_older, i_cfg.crc_polynomial) : r_crc;
        n_older = r_newer;
        n_newer = b;
        n_count = (r_count < COUNT_MAX) ? r_count + 9'd1 : r_count;
    end

    always_comb begin
        o_work.pay_valid      = (r_count >= PAYLOAD_START);
        o_work.pay_byte       = r_older;
        o_work.sum_valid      = last;
        o_work.src_addr       = n_src;
        o_work.dest_node      = n_dst;
        o_work.message_type   = n_typ;
        o_work.message_id     = n_id;
        o_work.received_crc   = {b, r_newer};
        o_work.crc_calc       = n_crc;
        o_work.too_short      = (r_count < MIN_FRAME_M1);
        o_work.sync_ok        = n_sync;
        o_work.too_long       = (diff > {1'b0, i_cfg.payload_limit});
        o_work.payload_length = o_work.too_short ? 8'd0 : (diff[8] ? 8'hFF : diff[7:0]);
        o_push = i_accept && (o_work.pay_valid || last);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_crc   <= '0;
            r_newer <= '0;
            r_older <= '0;
            r_sync  <= 1'b1;
            r_src   <= '0;
            r_dst   <= '0;
            r_typ   <= '0;
            r_id    <= '0;
        end else if (i_accept) begin
            if (last) begin
                r_count <= '0;
                r_crc   <= '0;
                r_newer <= '0;
                r_older <= '0;
                r_sync  <= 1'b1;
                r_src   <= '0;
                r_dst   <= '0;
                r_typ   <= '0;
                r_id    <= '0;
            end else begin
                r_count <= n_count;
                r_crc   <= n_crc;
                r_newer <= n_newer;
                r_older <= n_older;
                r_sync  <= n_sync;
                r_src   <= n_src;
                r_dst   <= n_dst;
                r_typ   <= n_typ;
                r_id    <= n_id;
            end
        end
    end

endmodule

@@ sv/fcc16_queue.sv @@
// Small register queue of classified items between the front and back ends.
module fcc16_queue #(
    parameter int DEPTH = fcc16_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  fcc16_pkg::t_work  i_data,
    input  logic              i_pop,
    output fcc16_pkg::t_work  o_data,
    output logic              o_full,
    output logic              o_empty
);
    import fcc16_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    t_work            r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= (r_wr == PTR_LAST) ? '0 : r_wr + PTR_W'(1);
            if (do_pop)  r_rd <= (r_rd == PTR_LAST) ? '0 : r_rd + PTR_W'(1);
            if (do_push && !do_pop)      r_cnt <= r_cnt + CNT_W'(1);
            else if (do_pop && !do_push) r_cnt <= r_cnt - CNT_W'(1);
        end
    end

endmodule

@@ sv/fcc16_back.sv @@
// Back end: holds one classified item, settles the status and hands out its results.
module fcc16_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_q_empty,
    input  fcc16_pkg::t_work  i_q_data,
    output logic              o_q_pop,
    input  logic              i_pop,
    output logic              o_empty,
    output fcc16_pkg::t_out   o_out
);
    import fcc16_pkg::*;

    logic  r_valid;
    logic  r_pay_pend;
    t_work r_work;
    logic  take, done;

    assign o_empty = !r_valid;
    // The item is finished when its last result is taken.
    assign done    = i_pop && r_valid && !(r_pay_pend && r_work.sum_valid);
    assign take    = !r_valid || done;
    assign o_q_pop = take && !i_q_empty;

    always_comb begin
        o_out = '0;
        if (r_pay_pend) begin
            o_out.result_kind  = KIND_PAYLOAD;
            o_out.payload_byte = r_work.pay_byte;
            o_out.last_of_run  = !r_work.sum_valid;
        end else begin
            o_out.result_kind    = KIND_SUMMARY;
            o_out.src_addr       = r_work.src_addr;
            o_out.dest_node      = r_work.dest_node;
            o_out.message_type   = r_work.message_type;
            o_out.message_id     = r_work.message_id;
            o_out.received_crc   = r_work.received_crc;
            o_out.payload_length = r_work.payload_length;
            o_out.last_of_run    = 1'b1;
            priority if (r_work.too_short)                       o_out.status = ST_TOO_SHORT;
            else if (!r_work.sync_ok)                            o_out.status = ST_BAD_SYNC;
            else if (r_work.too_long)                            o_out.status = ST_TOO_LONG;
            else if (r_work.crc_calc != r_work.received_crc)     o_out.status = ST_CRC_BAD;
            else                                                 o_out.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_pay_pend <= 1'b0;
        end else if (take) begin
            r_valid    <= !i_q_empty;
            r_pay_pend <= !i_q_empty && i_q_data.pay_valid;
        end else if (i_pop) begin
            // payload taken, summary still to go
            r_pay_pend <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && !i_q_empty) r_work <= i_q_data;
    end

endmodule

@@ sv/frame_checker_crc16.sv @@
// Top level: frame checker with CRC-16, configuration registers and queue interface.
//
// Frame checker with CRC-16. Push one frame byte per item, with end_of_frame set
// on the last byte; the block accepts one item every clock cycle while full is
// low. Frame bytes 0 and 1 are compared against the sync registers, bytes 2..6
// give source, destination, type and a little-endian message id, and the last
// two bytes are a little-endian CRC. Each payload byte leaves as a kind 0 item,
// two bytes late, and the last byte adds a kind 1 summary with the header,
// payload length and status. The CRC of a byte is one unrolled eight-step
// update in the front end, so the front end never stalls by itself; it stalls
// only when the queue (four entries by default) before the result register is
// full. An input byte yields at most two results, and the result side hands
// out one per cycle, so a frame byte that closes a frame with payload costs
// the consumer two pops. Configuration writes take effect at once and must be
// made between frames. There is no clearing pass after reset.
module frame_checker_crc16 #(
    parameter int QUEUE_DEPTH = fcc16_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  fcc16_pkg::t_in                     i_in,
    output logic                               empty,
    input  logic                               pop,
    output fcc16_pkg::t_out                    o_out,
    input  logic                               i_cfg_we,
    input  logic [fcc16_pkg::CFG_INDEX_W-1:0]  i_cfg_index,
    input  logic [15:0]                        i_cfg_data
);
    import fcc16_pkg::*;

    t_cfg  r_cfg;
    t_work front_work, q_data;
    logic  accept, front_push, q_full, q_empty, q_pop;

    // Config registers: drop writes beyond the list, mask values to width.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sync_first     <= 8'd0;
            r_cfg.sync_second    <= 8'd0;
            r_cfg.crc_polynomial <= 16'h1021;
            r_cfg.payload_limit  <= 8'd64;
        end else if (i_cfg_we && i_cfg_index[CFG_INDEX_W-1:2] == '0) begin
            unique case (i_cfg_index[1:0])
                CFG_SYNC_FIRST:  r_cfg.sync_first     <= i_cfg_data[7:0];
                CFG_SYNC_SECOND: r_cfg.sync_second    <= i_cfg_data[7:0];
                CFG_CRC_POLY:    r_cfg.crc_polynomial <= i_cfg_data;
                CFG_PAY_LIMIT:   r_cfg.payload_limit  <= i_cfg_data[7:0];
                default:         ;
            endcase
        end
    end

    // Hold input while the queue has no room for a classified item.
    assign full   = q_full;
    assign accept = push && !q_full;

    fcc16_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_in     (i_in),
        .i_cfg    (r_cfg),
        .o_push   (front_push),
        .o_work   (front_work)
    );

    fcc16_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_data  (front_work),
        .i_pop   (q_pop),
        .o_data  (q_data),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // Advance results to the consumer one result per pop.
    fcc16_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (q_data),
        .o_q_pop   (q_pop),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_out     (o_out)
    );

endmodule
